// ----- rtl/brm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brm_pkg: shared constants and helpers for Barrett modular reduction
// Field widths, the partial-product split and the leading-one search.
// ----------------------------------------------------------------------------
package brm_pkg;

  localparam int unsigned XW          = 64;  // input value width
  localparam int unsigned RW          = 32;  // remainder width
  localparam int unsigned CFG_W       = 32;  // modulus register width
  localparam int unsigned HW          = 32;  // partial-product split
  localparam int unsigned MOD_WIDTH_D = 32;  // default modulus width
  localparam int unsigned TBW         = $clog2(CFG_W);

  // Index of the highest set bit, zero for zero.
  function automatic logic [TBW-1:0] top_bit(logic [CFG_W-1:0] v);
    logic [TBW-1:0] k;
    k = '0;
    for (int i = 0; i < CFG_W; i++) begin
      if (v[i]) begin
        k = TBW'(i);
      end
    end
    return k;
  endfunction

endpackage

// ----- rtl/brm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brm_div: Barrett factor precompute
// Bit-serial restoring division mu = floor(2^s / n), one quotient bit per
// cycle, s+1 quotient bits in all. A zero modulus gives mu = 0 at once.
// ----------------------------------------------------------------------------
module brm_div #(
  parameter int unsigned NW = brm_pkg::CFG_W,
  parameter int unsigned SW = brm_pkg::TBW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] n_i,
  input  logic [SW-1:0] s_i,
  output logic          busy_o,
  output logic [NW-1:0] mu_o
);

  logic          run_q, run_d;
  logic [SW-1:0] idx_q, idx_d;
  logic [NW:0]   rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [NW:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q[NW-1:0], (idx_q == s_i)};
    ge     = rem_sh >= {1'b0, n_i};
  end

  always_comb begin
    run_d = run_q;
    idx_d = idx_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = '0;
      idx_d = s_i;
      run_d = (n_i != '0);
    end else if (run_q) begin
      rem_d = ge ? (rem_sh - {1'b0, n_i}) : rem_sh;
      quo_d = {quo_q[NW-2:0], ge};
      idx_d = idx_q - SW'(1);
      if (idx_q == '0) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      idx_q <= '0;
      rem_q <= '0;
      quo_q <= NW'(1);
    end else begin
      run_q <= run_d;
      idx_q <= idx_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = run_q;
  assign mu_o   = quo_q;

endmodule

// ----- rtl/barrett_modular_reduction_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barrett_modular_reduction_top: pipelined Barrett reduction
// Reduces a 64-bit value modulo a configured modulus, one value per cycle while busy_o is low.
// ----------------------------------------------------------------------------
// A value is taken on every cycle with start_i high and busy_o low; its
// remainder and range flag come out with done_o at the end of the pipeline,
// and the receiver cannot hold them off. The seven-stage datapath (two
// split multiplies, product sum, shift, two more split multiplies, product
// sum, subtract, correction) sustains one value per cycle while busy_o is low.
// Writing the modulus starts a bit-serial division for mu = floor(2^(2k) / n),
// k = floor(log2 n); busy_o is high and cfg_ready_o low while it runs.
// A zero modulus completes at once.
// ----------------------------------------------------------------------------
module barrett_modular_reduction_top #(
  parameter int unsigned MOD_WIDTH = brm_pkg::MOD_WIDTH_D
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [brm_pkg::XW-1:0]  value_in_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [brm_pkg::CFG_W-1:0] modulus_i,
  output logic                    done_o,
  output logic [brm_pkg::RW-1:0]  remainder_o,
  output logic                    range_flag_o
);

  localparam int unsigned XW  = brm_pkg::XW;
  localparam int unsigned HW  = brm_pkg::HW;
  localparam int unsigned RW  = brm_pkg::RW;
  localparam int unsigned NW  = (MOD_WIDTH < brm_pkg::CFG_W) ? MOD_WIDTH : brm_pkg::CFG_W;
  localparam int unsigned SW  = $clog2(2 * NW - 1);
  localparam int unsigned PW  = HW + NW;
  localparam int unsigned MW  = XW + NW;
  localparam int unsigned NST = 7;

  logic          cfg_fire, in_fire, div_busy;
  logic [NW-1:0] n_q, n_d, n_cfg, mu;
  logic [SW-1:0] s_q, s_d;

  assign n_cfg       = modulus_i[NW-1:0];
  assign cfg_ready_o = ~div_busy;
  assign busy_o      = div_busy;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_fire     = start_i & ~busy_o;

  always_comb begin
    n_d = n_q;
    s_d = s_q;
    if (cfg_fire) begin
      n_d = n_cfg;
      s_d = SW'({brm_pkg::top_bit(brm_pkg::CFG_W'(n_cfg)), 1'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= NW'(1);
      s_q <= '0;
    end else begin
      n_q <= n_d;
      s_q <= s_d;
    end
  end

  brm_div #(
    .NW (NW),
    .SW (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_fire),
    .n_i     (n_d),
    .s_i     (s_d),
    .busy_o  (div_busy),
    .mu_o    (mu)
  );

  // Valid chain
  logic [NST-1:0] v_q, v_d;

  assign v_d = {v_q[NST-2:0], in_fire};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Datapath
  logic [XW-1:0] x1_q, x2_q, x3_q, x4_q, x5_q;
  logic          f1_q, f2_q, f3_q, f4_q, f5_q, f6_q, f7_q;
  logic [PW-1:0] pa1_q, pa1_d, pb1_q, pb1_d;
  logic [MW-1:0] pr2_q, pr2_d;
  logic [XW-1:0] q3_q, q3_d;
  logic [PW-1:0] qa4_q, qa4_d, qbf;
  logic [HW-1:0] qb4_q, qb4_d;
  logic [XW-1:0] qn5_q, qn5_d;
  logic [XW-1:0] t6_q, t6_d;
  logic [RW-1:0] r7_q, r7_d;
  logic          f1_d;
  logic [XW-1:0] n_ext;

  assign n_ext = XW'(n_q);

  always_comb begin
    pa1_d = PW'(value_in_i[HW-1:0]) * PW'(mu);
    pb1_d = PW'(value_in_i[XW-1:HW]) * PW'(mu);
    f1_d  = (value_in_i >> s_q) != '0;
    pr2_d = MW'(pa1_q) + (MW'(pb1_q) << HW);
    q3_d  = XW'(pr2_q >> s_q);
    qa4_d = PW'(q3_q[HW-1:0]) * PW'(n_q);
    qbf   = PW'(q3_q[XW-1:HW]) * PW'(n_q);
    qb4_d = qbf[HW-1:0];
    qn5_d = XW'(qa4_q) + (XW'(qb4_q) << HW);
    t6_d  = x5_q - qn5_q;
    r7_d  = (t6_q >= n_ext) ? RW'(t6_q - n_ext) : RW'(t6_q);
  end

  always_ff @(posedge clk_i) begin
    x1_q  <= value_in_i;
    pa1_q <= pa1_d;
    pb1_q <= pb1_d;
    f1_q  <= f1_d;
    x2_q  <= x1_q;
    pr2_q <= pr2_d;
    f2_q  <= f1_q;
    x3_q  <= x2_q;
    q3_q  <= q3_d;
    f3_q  <= f2_q;
    x4_q  <= x3_q;
    qa4_q <= qa4_d;
    qb4_q <= qb4_d;
    f4_q  <= f3_q;
    x5_q  <= x4_q;
    qn5_q <= qn5_d;
    f5_q  <= f4_q;
    t6_q  <= t6_d;
    f6_q  <= f5_q;
    r7_q  <= r7_d;
    f7_q  <= f6_q;
  end

  assign done_o       = v_q[NST-1];
  assign remainder_o  = r7_q;
  assign range_flag_o = f7_q;

endmodule
